@@ hw/rtl/rotating_binaural_panner_defines.svh @@
// ---------------------------------------------------------------------------
// Assertion helpers for the rotating binaural panner.
// Both expect i_clk and i_rst_n in scope where they are used.
// ---------------------------------------------------------------------------
`ifndef ROTATING_BINAURAL_PANNER_DEFINES_SVH
`define ROTATING_BINAURAL_PANNER_DEFINES_SVH

// Same-cycle implication, checked out of reset only.
`define RBP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset only.
`define RBP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/rbp_pkg.sv @@
// ---------------------------------------------------------------------------
// rbp_pkg
// Constants and types shared by the rotating binaural panner.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rbp_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_PHASE_STEP  = 2'd0;
    localparam logic [1:0] CFG_DELAY_MODE  = 2'd1;
    localparam logic [1:0] CFG_DELAY_SCALE = 2'd2;

    localparam logic [15:0] DELAY_SCALE_RST = 16'd7987;

    // Sine polynomial coefficients, Q16.
    localparam logic [16:0] SIN_A = 17'd102944;
    localparam logic [16:0] SIN_B = 17'd42048;
    localparam logic [16:0] SIN_C = 17'd4640;

    // 2*pi in Q16 and the spherical head factor in Q16.
    localparam logic [19:0] TWO_PI_Q16 = 20'd411775;
    localparam logic [19:0] WOOD_K_Q16 = 20'd25948;

    // Gain angle offsets in 1/131072 turn.
    localparam logic [16:0] GAIN_OFS_R = 17'd16384;
    localparam logic [16:0] GAIN_OFS_L = 17'd49152;

    localparam int OUT_BITS = 24;

    // Which value a sine evaluation produces.
    typedef enum logic [1:0] {
        SEL_DELAY,
        SEL_GAIN_L,
        SEL_GAIN_R
    } t_sin_sel;

endpackage

`default_nettype wire

@@ hw/rtl/rotating_binaural_panner.sv @@
// ---------------------------------------------------------------------------
// rotating_binaural_panner
// Mono to binaural panner with a rotating source, interaural delay and
// constant-power gains, computed on one shared multiplier.
// ---------------------------------------------------------------------------
// Each request is worked through from acceptance to result in the simple delay
// mode or the spherical head mode, and s_axis_tready stays low until the result
// is in the output register. All arithmetic goes through a single registered
// signed multiplier: three sine polynomials of four products each, two products
// for the spherical head term, one for the delay scale, one for interpolation
// and two for the ear gains. The sample ring is a single-port memory with
// registered read data; both interpolation taps are read in turn. A finished
// result sits in the output register while the next request is accepted. The
// ring reads as zero until each entry has been written once; a fill count
// tracks that, so no clearing pass is needed.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "rotating_binaural_panner_defines.svh"

module rotating_binaural_panner #(
    parameter int RING_DEPTH  = 64,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // Configuration write channel.
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [1:0]             i_cfg_index,
    input  wire logic [15:0]            i_cfg_data,
    // Input stream. tdata: sample_in (SAMPLE_BITS, signed), zero padded.
    input  wire logic                   s_axis_tvalid,
    output logic                        s_axis_tready,
    input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0] s_axis_tdata,
    // Output stream. tdata: left_out [23:0], right_out [47:24].
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [47:0]                 m_axis_tdata
);

    localparam int AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int SPAN  = RING_DEPTH * 256;
    localparam int PSW   = $clog2(SPAN) + 1;
    localparam int DW    = (PSW > 17) ? PSW : 17;
    localparam int MA_W  = (SAMPLE_BITS + 1 > 20) ? SAMPLE_BITS + 1 : 20;
    localparam int MB_W  = 20;
    localparam int PW    = MA_W + MB_W;
    localparam int OB    = rbp_pkg::OUT_BITS;
    localparam logic [DW-1:0] DMAX = DW'((RING_DEPTH - 1) * 256);
    localparam logic [AW-1:0] WP_LAST = AW'(RING_DEPTH - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_WAIT, S_SIN_A, S_SIN_B, S_SIN_C, S_SIN_D,
        S_WOOD_A, S_WOOD_B, S_SCALE, S_RD_A, S_RD_B, S_RD_C,
        S_INTERP, S_GAIN_L, S_GAIN_R, S_OUT
    } t_state;

    t_state                  r_state, r_after;
    rbp_pkg::t_sin_sel       r_sel;

    logic [15:0]             r_phase_step, r_delay_scale, r_phase, r_p;
    logic                    r_delay_mode;
    logic [AW-1:0]           r_wp, r_raddr, r_i2;
    logic [AW:0]             r_fill;
    logic [7:0]              r_frac;
    logic [DW-1:0]           r_d;
    logic                    r_neg;
    logic [16:0]             r_x, r_x2;
    logic [17:0]             r_s;
    logic signed [17:0]      r_gl, r_gr;
    logic [14:0]             r_fold;
    logic signed [SAMPLE_BITS-1:0] r_samp, r_a, r_far, r_rdata;
    logic                    r_rvalid;
    logic signed [OB-1:0]    r_left_res, r_left, r_right;
    logic                    r_out_valid;
    logic signed [MA_W-1:0]  r_ma;
    logic signed [MB_W-1:0]  r_mb;
    logic signed [PW-1:0]    r_prod;
    logic signed [SAMPLE_BITS-1:0] r_ring [RING_DEPTH];

    logic signed [PW-1:0]    n_prod;
    logic                    in_acc;
    logic signed [SAMPLE_BITS-1:0] n_samp;

    // Neither channel takes a request while reset is held.
    assign n_prod        = r_ma * r_mb;
    assign s_axis_tready = i_rst_n && (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign n_samp        = s_axis_tdata[SAMPLE_BITS-1:0];
    assign o_cfg_ready   = i_rst_n;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_right, r_left};

    // Quadrant reduction of an angle in 1/131072 turn to a Q16 argument.
    function automatic logic [17:0] sin_arg(input logic [16:0] a);
        logic [16:0] x;
        x = {1'b0, a[14:0], 1'b0};
        if (a[15]) begin
            x = 17'd65536 - x;
        end
        return {a[16], x};
    endfunction

    function automatic logic signed [MA_W-1:0] ext_u18(input logic [17:0] v);
        return $signed({{(MA_W-18){1'b0}}, v});
    endfunction

    function automatic logic signed [MA_W-1:0] ext_smp(
        input logic signed [SAMPLE_BITS-1:0] v);
        return $signed({{(MA_W-SAMPLE_BITS){v[SAMPLE_BITS-1]}}, v});
    endfunction

    // Floor of a Q16 gain product, saturated to the output width.
    function automatic logic signed [OB-1:0] sat_out(input logic signed [PW-1:0] p);
        logic signed [PW-17:0] v;
        v = p[PW-1:16];
        if (v > $signed((PW-16)'((1 << (OB - 1)) - 1))) begin
            return OB'((1 << (OB - 1)) - 1);
        end else if (v < -$signed((PW-16)'(1 << (OB - 1)))) begin
            return OB'(1 << (OB - 1));
        end
        return v[OB-1:0];
    endfunction

    // Sample ring, single port, registered read.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_ring[r_wp] <= n_samp;
        end
        r_rdata  <= r_ring[r_raddr];
        r_rvalid <= ({1'b0, r_raddr} < r_fill);
    end

    always_ff @(posedge i_clk) begin
        logic [17:0]   arg;
        logic [16:0]   ang;
        logic [DW-1:0] d_raw, d_cl;
        logic [DW:0]   pos;
        logic [AW-1:0] i1;
        logic signed [17:0] g;
        logic signed [SAMPLE_BITS-1:0] b, near;
        r_prod <= n_prod;
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_after       <= S_IDLE;
            r_sel         <= rbp_pkg::SEL_DELAY;
            r_phase_step  <= '0;
            r_delay_mode  <= 1'b0;
            r_delay_scale <= rbp_pkg::DELAY_SCALE_RST;
            r_phase       <= '0;
            r_wp          <= '0;
            r_fill        <= '0;
            r_d           <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    rbp_pkg::CFG_PHASE_STEP:  r_phase_step  <= i_cfg_data;
                    rbp_pkg::CFG_DELAY_MODE:  r_delay_mode  <= i_cfg_data[0];
                    rbp_pkg::CFG_DELAY_SCALE: r_delay_scale <= i_cfg_data;
                    default: ;
                endcase
            end
            if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_samp  <= n_samp;
                        r_p     <= r_phase;
                        r_phase <= r_phase + r_phase_step;
                        if (r_fill != (AW+1)'(RING_DEPTH)) begin
                            r_fill <= r_fill + 1'b1;
                        end
                        // Fold to the distance from front or back.
                        if (r_phase[14:0] <= 15'd16384) begin
                            r_fold <= r_phase[14:0];
                            r_x    <= {r_phase[14:0], 2'b00};
                            r_ma   <= ext_u18({1'b0, r_phase[14:0], 2'b00});
                            r_mb   <= $signed({3'b0, r_phase[14:0], 2'b00});
                        end else begin
                            r_fold <= 15'd16384 - (r_phase[14:0] - 15'd16384);
                            r_x    <= {15'd16384 - (r_phase[14:0] - 15'd16384), 2'b00};
                            r_ma   <= ext_u18({1'b0,
                                      15'd16384 - (r_phase[14:0] - 15'd16384), 2'b00});
                            r_mb   <= $signed({3'b0,
                                      15'd16384 - (r_phase[14:0] - 15'd16384), 2'b00});
                        end
                        r_neg   <= 1'b0;
                        r_sel   <= rbp_pkg::SEL_DELAY;
                        r_after <= S_SIN_A;
                        r_state <= S_WAIT;
                    end
                end
                S_WAIT: begin
                    r_state <= r_after;
                end
                S_SIN_A: begin
                    r_x2    <= r_prod[16 +: 17];
                    r_ma    <= ext_u18({1'b0, r_prod[16 +: 17]});
                    r_mb    <= $signed({3'b0, rbp_pkg::SIN_C});
                    r_after <= S_SIN_B;
                    r_state <= S_WAIT;
                end
                S_SIN_B: begin
                    r_ma    <= ext_u18({1'b0, r_x2});
                    r_mb    <= $signed({3'b0, rbp_pkg::SIN_B - r_prod[16 +: 17]});
                    r_after <= S_SIN_C;
                    r_state <= S_WAIT;
                end
                S_SIN_C: begin
                    r_ma    <= ext_u18({1'b0, r_x});
                    r_mb    <= $signed({3'b0, rbp_pkg::SIN_A - r_prod[16 +: 17]});
                    r_after <= S_SIN_D;
                    r_state <= S_WAIT;
                end
                S_SIN_D: begin
                    g = r_neg ? -$signed(r_prod[16 +: 18]) : $signed(r_prod[16 +: 18]);
                    case (r_sel)
                        rbp_pkg::SEL_DELAY: begin
                            r_s <= r_prod[16 +: 18];
                            if (r_delay_mode) begin
                                r_ma    <= ext_u18({3'b0, r_fold});
                                r_mb    <= $signed(rbp_pkg::TWO_PI_Q16);
                                r_after <= S_WOOD_A;
                            end else begin
                                r_ma    <= ext_u18(r_prod[16 +: 18]);
                                r_mb    <= $signed({4'b0, r_delay_scale});
                                r_after <= S_SCALE;
                            end
                        end
                        rbp_pkg::SEL_GAIN_L: begin
                            r_gl    <= g;
                            ang      = {1'b0, r_p} + rbp_pkg::GAIN_OFS_R;
                            arg      = sin_arg(ang);
                            r_neg   <= arg[17];
                            r_x     <= arg[16:0];
                            r_ma    <= ext_u18({1'b0, arg[16:0]});
                            r_mb    <= $signed({3'b0, arg[16:0]});
                            r_sel   <= rbp_pkg::SEL_GAIN_R;
                            r_after <= S_SIN_A;
                        end
                        default: begin
                            r_gr   <= g;
                            // Position of the far-ear tap behind the write index.
                            pos     = {1'b0, DW'({r_wp, 8'b0})} + (DW+1)'(SPAN)
                                      - {1'b0, r_d};
                            if (pos >= (DW+1)'(SPAN)) begin
                                pos = pos - (DW+1)'(SPAN);
                            end
                            i1      = pos[AW+7:8];
                            r_frac  <= pos[7:0];
                            r_raddr <= i1;
                            r_i2    <= (i1 == WP_LAST) ? '0 : i1 + 1'b1;
                            r_after <= S_RD_A;
                        end
                    endcase
                    r_state <= S_WAIT;
                end
                S_WOOD_A: begin
                    r_ma    <= ext_u18({1'b0, r_prod[16 +: 17]} + r_s);
                    r_mb    <= $signed(rbp_pkg::WOOD_K_Q16);
                    r_after <= S_WOOD_B;
                    r_state <= S_WAIT;
                end
                S_WOOD_B: begin
                    r_ma    <= ext_u18(r_prod[16 +: 18]);
                    r_mb    <= $signed({4'b0, r_delay_scale});
                    r_after <= S_SCALE;
                    r_state <= S_WAIT;
                end
                S_SCALE: begin
                    d_raw    = DW'(r_prod[16 +: 17]);
                    d_cl     = (d_raw > DMAX) ? DMAX : d_raw;
                    r_d     <= d_cl;
                    ang      = {1'b0, r_p} + rbp_pkg::GAIN_OFS_L;
                    arg      = sin_arg(ang);
                    r_neg   <= arg[17];
                    r_x     <= arg[16:0];
                    r_ma    <= ext_u18({1'b0, arg[16:0]});
                    r_mb    <= $signed({3'b0, arg[16:0]});
                    r_sel   <= rbp_pkg::SEL_GAIN_L;
                    r_after <= S_SIN_A;
                    r_state <= S_WAIT;
                end
                S_RD_A: begin
                    r_raddr <= r_i2;
                    r_state <= S_RD_B;
                end
                S_RD_B: begin
                    r_a     <= r_rvalid ? r_rdata : '0;
                    r_state <= S_RD_C;
                end
                S_RD_C: begin
                    b        = r_rvalid ? r_rdata : '0;
                    r_ma    <= ext_smp(b) - ext_smp(r_a);
                    r_mb    <= $signed({12'b0, r_frac});
                    r_after <= S_INTERP;
                    r_state <= S_WAIT;
                end
                S_INTERP: begin
                    // Left ear is delayed when the source is on the right.
                    r_far   <= r_a + r_prod[8 +: SAMPLE_BITS];
                    if (r_p != 16'd0 && !r_p[15]) begin
                        r_ma <= ext_smp(r_a + r_prod[8 +: SAMPLE_BITS]);
                    end else begin
                        r_ma <= ext_smp(r_samp);
                    end
                    r_mb    <= MB_W'(r_gl);
                    r_after <= S_GAIN_L;
                    r_state <= S_WAIT;
                end
                S_GAIN_L: begin
                    near        = r_samp;
                    r_left_res <= sat_out(r_prod);
                    if (r_p != 16'd0 && !r_p[15]) begin
                        r_ma <= ext_smp(near);
                    end else begin
                        r_ma <= ext_smp(r_far);
                    end
                    r_mb    <= MB_W'(r_gr);
                    r_after <= S_GAIN_R;
                    r_state <= S_WAIT;
                end
                S_GAIN_R: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_out_valid || m_axis_tready) begin
                        r_left      <= r_left_res;
                        r_right     <= sat_out(r_prod);
                        r_out_valid <= 1'b1;
                        r_wp        <= (r_wp == WP_LAST) ? '0 : r_wp + 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `RBP_ASSERT_NXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request accepted but input still ready")
    `RBP_ASSERT_IMP(a_delay_clamped, 1'b1, r_d <= DMAX, "delay exceeds ring depth")
    `RBP_ASSERT_IMP(a_fill_bound, 1'b1, r_fill <= (AW+1)'(RING_DEPTH), "fill count beyond ring depth")
    `RBP_ASSERT_IMP(a_wp_written, r_state != S_IDLE, {1'b0, r_wp} < r_fill, "current write entry not counted as filled")

endmodule

`default_nettype wire
